>>> rtl/mld_pkg.sv
package mld_pkg;

	localparam int IDX_BITS = 2;
	localparam int LEN_FIELD_BITS = 31;

	localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [1:0] KIND_EMPTY     = 2'd1;
	localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
	localparam logic [1:0] KIND_TOO_LARGE = 2'd3;

	localparam logic [IDX_BITS-1:0] REG_MAGIC_WORD = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_MAX_LENGTH = 2'd1;

	localparam logic [31:0] MAGIC_RESET = 32'h5443_504D;
	localparam logic [LEN_FIELD_BITS-1:0] MAX_LENGTH_RESET = 31'h7FFF_FFFF;

	localparam logic [2:0] HDR_LAST_COUNT = 3'd7;

	typedef struct packed {
		logic [31:0]               magic_word;
		logic [LEN_FIELD_BITS-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [LEN_FIELD_BITS-1:0] message_length;
		logic                      last_of_message;
		logic                      first_of_message;
		logic [1:0]                kind;
		logic [7:0]                out_byte;
	} res_t;

endpackage

>>> rtl/mld_cfg.sv
module mld_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mld_pkg::IDX_BITS-1:0]  wr_index,
	input  logic [31:0]                   wr_data,
	output mld_pkg::cfg_t                 cfg
);

	logic [31:0]                          magic_word_q;
	logic [mld_pkg::LEN_FIELD_BITS-1:0]   max_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= mld_pkg::MAGIC_RESET;
			max_length_q <= mld_pkg::MAX_LENGTH_RESET;
		end else if (wr_en) begin
			if (wr_index == mld_pkg::REG_MAGIC_WORD) begin
				magic_word_q <= wr_data;
			end
			if (wr_index == mld_pkg::REG_MAX_LENGTH) begin
				max_length_q <= wr_data[mld_pkg::LEN_FIELD_BITS-1:0];
			end
		end
	end

	assign cfg = {magic_word_q, max_length_q};

endmodule

>>> rtl/mld_parse.sv
module mld_parse #(
	parameter int LENGTH_BITS = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  mld_pkg::cfg_t cfg,
	output logic          res_valid,
	output mld_pkg::res_t res
);

	logic                   in_payload_q;
	logic [55:0]            header_bytes_q;
	logic [2:0]             header_count_q;
	logic [LENGTH_BITS-1:0] payload_length_q;
	logic [LENGTH_BITS-1:0] payload_count_q;

	logic [63:0]            full_hdr;
	logic [31:0]            hdr_magic;
	logic [31:0]            hdr_len;
	logic                   hdr_done;
	logic                   magic_bad;
	logic                   len_bad;
	logic                   len_zero;
	logic [LENGTH_BITS-1:0] count_next;
	logic                   pay_last;

	assign full_hdr   = {header_bytes_q, in_byte};
	assign hdr_magic  = full_hdr[63:32];
	assign hdr_len    = full_hdr[31:0];
	assign hdr_done   = !in_payload_q && (header_count_q == mld_pkg::HDR_LAST_COUNT);
	assign magic_bad  = hdr_magic != cfg.magic_word;
	// The top bit covers negative lengths; the shift covers lengths wider than the counter.
	assign len_bad    = hdr_len[31] || (hdr_len[30:0] > cfg.max_length)
	                    || ((hdr_len >> LENGTH_BITS) != 32'd0);
	assign len_zero   = hdr_len == 32'd0;
	assign count_next = payload_count_q + LENGTH_BITS'(1);
	assign pay_last   = count_next == payload_length_q;

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (in_payload_q) begin
			res_valid            = 1'b1;
			res.out_byte         = in_byte;
			res.kind             = mld_pkg::KIND_PAYLOAD;
			res.first_of_message = payload_count_q == '0;
			res.last_of_message  = pay_last;
			res.message_length   = mld_pkg::LEN_FIELD_BITS'(payload_length_q);
		end else if (hdr_done) begin
			priority if (magic_bad) begin
				res_valid = 1'b1;
				res.kind  = mld_pkg::KIND_BAD_MAGIC;
			end else if (len_bad) begin
				res_valid = 1'b1;
				res.kind  = mld_pkg::KIND_TOO_LARGE;
			end else if (len_zero) begin
				res_valid           = 1'b1;
				res.kind            = mld_pkg::KIND_EMPTY;
				res.last_of_message = 1'b1;
			end else begin
				res_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q     <= 1'b0;
			header_bytes_q   <= '0;
			header_count_q   <= '0;
			payload_length_q <= '0;
			payload_count_q  <= '0;
		end else if (accept) begin
			if (in_payload_q) begin
				if (pay_last) begin
					in_payload_q    <= 1'b0;
					payload_count_q <= '0;
				end else begin
					payload_count_q <= count_next;
				end
			end else if (hdr_done) begin
				header_bytes_q <= '0;
				header_count_q <= '0;
				if (!magic_bad && !len_bad && !len_zero) begin
					in_payload_q     <= 1'b1;
					payload_length_q <= hdr_len[LENGTH_BITS-1:0];
					payload_count_q  <= '0;
				end
			end else begin
				header_bytes_q <= full_hdr[55:0];
				header_count_q <= header_count_q + 3'd1;
			end
		end
	end

	a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (payload_length_q != '0))
		else $error("payload phase with zero length");

	a_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (payload_count_q < payload_length_q))
		else $error("payload count reached the length");

	a_header_idle_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (header_count_q == 3'd0))
		else $error("header bytes gathered during payload");

	a_enter_payload_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_payload_q) |-> (payload_count_q == '0))
		else $error("payload started with a stale count");

endmodule

>>> rtl/mld_out.sv
module mld_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          res_valid,
	input  mld_pkg::res_t res,
	input  logic          out_ready,
	output logic          in_ready,
	output logic          out_valid,
	output mld_pkg::res_t out_res
);

	logic          valid_q;
	mld_pkg::res_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= res_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			res_q <= res;
		end
	end

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |-> !accept)
		else $error("item accepted over a waiting result");

endmodule

>>> rtl/magic_length_message_deframer_top.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata, tuser, tlast (see ports)
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One byte is taken every clock cycle while the result register is free or being read.
// A result follows its byte in the next cycle; only the last header byte can give one.
// The header and payload logic sits between the parse state and one result register.
// Reset clears the parse state and loads the default magic word and length limit.
// A stalled output holds its result and blocks new bytes only while it is full.
module magic_length_message_deframer_top #(
	parameter int LENGTH_BITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [38:8] message_length, [39] zero
	output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] first_of_message
	output logic        m_axis_tlast,   // last_of_message
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mld_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	mld_pkg::cfg_t cfg;
	mld_pkg::res_t res;
	mld_pkg::res_t out_res;
	logic          res_valid;
	logic          accept;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;

	mld_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mld_parse #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_axis_tdata),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	mld_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {1'b0, out_res.message_length, out_res.out_byte};
	assign m_axis_tuser = {out_res.first_of_message, out_res.kind};
	assign m_axis_tlast = out_res.last_of_message;

endmodule

>>> tb/magic_length_message_deframer_top_test.sv
module magic_length_message_deframer_top_test;

	localparam int LENGTH_BITS = 31;
	localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 1);
	localparam int RANDOM_BYTES = 1650;
	localparam int CYCLE_LIMIT = 500000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	logic [7:0]                   s_axis_tdata = '0;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [39:0]                  m_axis_tdata;
	logic [2:0]                   m_axis_tuser;
	logic                         m_axis_tlast;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [mld_pkg::IDX_BITS-1:0] cfg_index = '0;
	logic [31:0]                  cfg_data = '0;

	magic_length_message_deframer_top #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow of the deframer state and its registers.
	logic                               in_msg = 1'b0;
	logic [55:0]                        hdr_shift = '0;
	logic [2:0]                         hdr_cnt = '0;
	logic [mld_pkg::LEN_FIELD_BITS-1:0] msg_len = '0;
	logic [mld_pkg::LEN_FIELD_BITS-1:0] msg_cnt = '0;
	logic [31:0]                        magic_cfg = mld_pkg::MAGIC_RESET;
	logic [mld_pkg::LEN_FIELD_BITS-1:0] limit_cfg = mld_pkg::MAX_LENGTH_RESET;

	logic [7:0]    stream_bytes[$];
	mld_pkg::res_t results_due[$];
	int            bytes_pushed = 0;
	int            bytes_accepted = 0;
	int            mismatch_count = 0;
	int            cycles = 0;
	bit            byte_taken = 1'b0;
	bit            cfg_taken = 1'b0;
	int            burst_left = 0;
	int            gap_left = 0;
	logic [15:0]   ready_mask = '1;
	logic [5:0]    ready_tick = '0;

	function automatic bit deframe_byte(input logic [7:0] b, output mld_pkg::res_t r);
		logic [63:0]                        hdr;
		logic [31:0]                        len;
		logic [mld_pkg::LEN_FIELD_BITS-1:0] nxt;
		r = '0;
		deframe_byte = 1'b0;
		if (in_msg) begin
			nxt = msg_cnt + 1'b1;
			r.out_byte = b;
			r.kind = mld_pkg::KIND_PAYLOAD;
			r.first_of_message = (msg_cnt == '0);
			r.last_of_message = (nxt == msg_len);
			r.message_length = msg_len;
			if (r.last_of_message) begin
				in_msg = 1'b0;
				msg_cnt = '0;
			end else begin
				msg_cnt = nxt;
			end
			deframe_byte = 1'b1;
		end else if (hdr_cnt != mld_pkg::HDR_LAST_COUNT) begin
			hdr_shift = {hdr_shift[47:0], b};
			hdr_cnt = hdr_cnt + 1'b1;
		end else begin
			hdr = {hdr_shift, b};
			len = hdr[31:0];
			hdr_shift = '0;
			hdr_cnt = '0;
			deframe_byte = 1'b1;
			if (hdr[63:32] != magic_cfg) begin
				r.kind = mld_pkg::KIND_BAD_MAGIC;
			end else if (len[31] || len > {1'b0, limit_cfg} || len > LEN_MASK) begin
				r.kind = mld_pkg::KIND_TOO_LARGE;
			end else if (len == '0) begin
				r.kind = mld_pkg::KIND_EMPTY;
				r.last_of_message = 1'b1;
			end else begin
				msg_len = len[mld_pkg::LEN_FIELD_BITS-1:0];
				msg_cnt = '0;
				in_msg = 1'b1;
				deframe_byte = 1'b0;
			end
		end
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < 100)
			$display("tb: mismatch in %s: got %0h, want %0h", what, got, want);
		mismatch_count++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		stream_bytes.push_back(b);
		bytes_pushed++;
	endtask

	task automatic push_header(input logic [31:0] magic, input logic [31:0] len);
		for (int i = 3; i >= 0; i--)
			push_byte(magic[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			push_byte(len[8*i +: 8]);
	endtask

	task automatic push_payload(input int n);
		repeat (n) push_byte(8'($urandom));
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (bytes_accepted != bytes_pushed || results_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Called at a falling edge; leaves cfg_valid high for the caller to drop.
	task automatic write_reg(input logic [mld_pkg::IDX_BITS-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk);
		while (!cfg_taken);
	endtask

	always @(posedge clk) begin
		mld_pkg::res_t r;
		mld_pkg::res_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			byte_taken = s_axis_tvalid && s_axis_tready;
			cfg_taken = cfg_valid && cfg_ready;
			if (byte_taken) begin
				bytes_accepted++;
				if (deframe_byte(s_axis_tdata, r))
					results_due.push_back(r);
			end
			if (cfg_taken) begin
				case (cfg_index)
					mld_pkg::REG_MAGIC_WORD: magic_cfg = cfg_data;
					mld_pkg::REG_MAX_LENGTH:
						limit_cfg = cfg_data[mld_pkg::LEN_FIELD_BITS-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					flag_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = results_due.pop_front();
					if (m_axis_tdata[7:0] !== want.out_byte)
						flag_mismatch("out_byte", m_axis_tdata[7:0], want.out_byte);
					if (m_axis_tdata[38:8] !== want.message_length)
						flag_mismatch("message_length", m_axis_tdata[38:8],
							want.message_length);
					if (m_axis_tdata[39] !== 1'b0)
						flag_mismatch("tdata pad bit", m_axis_tdata[39], 0);
					if (m_axis_tuser[1:0] !== want.kind)
						flag_mismatch("kind", m_axis_tuser[1:0], want.kind);
					if (m_axis_tuser[2] !== want.first_of_message)
						flag_mismatch("first_of_message", m_axis_tuser[2],
							want.first_of_message);
					if (m_axis_tlast !== want.last_of_message)
						flag_mismatch("last_of_message", m_axis_tlast, want.last_of_message);
				end
			end
		end
	end

	// Byte source: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (stream_bytes.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= stream_bytes.pop_front();
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: a 16-bit ready pattern, redrawn whenever the 6-bit tick counter wraps.
	always @(negedge clk) begin
		ready_tick = ready_tick + 1'b1;
		if (ready_tick == '0) begin
			case ($urandom_range(0, 3))
				0: ready_mask = '1;
				1: ready_mask = 16'($urandom) | 16'($urandom);
				2: ready_mask = 16'($urandom);
				default: ready_mask = 16'($urandom) & 16'($urandom);
			endcase
			if (ready_mask == '0)
				ready_mask = 16'd1;
		end
		m_axis_tready <= ready_mask[ready_tick[3:0]];
	end

	initial begin
		int          phase;
		int          start_bytes;
		int          target;
		int          fill;
		int          n;
		bit          cut;
		bit          wrote;
		logic [31:0] len;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		push_header(mld_pkg::MAGIC_RESET, 32'h0);
		push_header(32'h0, 32'h0);
		push_header(mld_pkg::MAGIC_RESET, 32'hFFFF_FFFF);
		push_header(mld_pkg::MAGIC_RESET, 32'd1);
		push_payload(1);
		wait_idle();

		phase = 0;
		while (bytes_pushed < RANDOM_BYTES + 33) begin
			wrote = 1'b0;
			case (phase)
				0: begin
					write_reg(mld_pkg::REG_MAGIC_WORD, 32'h0);
					write_reg(mld_pkg::REG_MAX_LENGTH, 32'h0);
					wrote = 1'b1;
				end
				1: begin
					write_reg(mld_pkg::REG_MAGIC_WORD, 32'hFFFF_FFFF);
					write_reg(mld_pkg::REG_MAX_LENGTH, 32'hFFFF_FFFF);
					wrote = 1'b1;
				end
				2: begin
					write_reg(mld_pkg::IDX_BITS'(2), $urandom);
					write_reg(mld_pkg::IDX_BITS'(3), $urandom);
					write_reg(mld_pkg::REG_MAGIC_WORD, mld_pkg::MAGIC_RESET);
					write_reg(mld_pkg::REG_MAX_LENGTH, $urandom_range(3, 15));
					wrote = 1'b1;
				end
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						case ($urandom_range(0, 3))
							0: write_reg(mld_pkg::REG_MAGIC_WORD, mld_pkg::MAGIC_RESET);
							1: write_reg(mld_pkg::REG_MAGIC_WORD, 32'h0);
							2: write_reg(mld_pkg::REG_MAGIC_WORD, 32'hFFFF_FFFF);
							default: write_reg(mld_pkg::REG_MAGIC_WORD, $urandom);
						endcase
						wrote = 1'b1;
					end
					if ($urandom_range(0, 1) == 0) begin
						case ($urandom_range(0, 4))
							0: write_reg(mld_pkg::REG_MAX_LENGTH, 32'h0);
							1: write_reg(mld_pkg::REG_MAX_LENGTH,
								{1'b0, mld_pkg::MAX_LENGTH_RESET});
							2: write_reg(mld_pkg::REG_MAX_LENGTH, $urandom_range(1, 20));
							3: write_reg(mld_pkg::REG_MAX_LENGTH, $urandom_range(20, 60));
							default: write_reg(mld_pkg::REG_MAX_LENGTH, $urandom);
						endcase
						wrote = 1'b1;
					end
					if ($urandom_range(0, 7) == 0) begin
						write_reg(mld_pkg::IDX_BITS'($urandom_range(2, 3)), $urandom);
						wrote = 1'b1;
					end
				end
			endcase
			if (wrote)
				cfg_valid <= 1'b0;

			// Finish any partial header or message so the next phase starts aligned.
			while (in_msg || hdr_cnt != '0) begin
				fill = in_msg ? int'(msg_len - msg_cnt) : 8 - int'(hdr_cnt);
				push_payload(fill);
				wait_idle();
			end

			start_bytes = bytes_pushed;
			target = $urandom_range(60, 140);
			cut = 1'b0;
			while (!cut && bytes_pushed - start_bytes < target) begin
				n = $urandom_range(0, 99);
				if (n < 70) begin
					case ($urandom_range(0, 9))
						0: len = 32'h0;
						1: len = (limit_cfg < 64) ? {1'b0, limit_cfg} + $urandom_range(0, 1)
							: 32'($urandom_range(1, 12));
						2: len = $urandom_range(13, 48);
						default: len = $urandom_range(1, 12);
					endcase
					push_header(magic_cfg, len);
					if (len != 0 && len <= {1'b0, limit_cfg})
						push_payload(len);
				end else if (n < 80) begin
					if ($urandom_range(0, 1) == 0)
						push_header(magic_cfg ^ (32'd1 << $urandom_range(0, 31)), $urandom);
					else
						push_header($urandom, $urandom);
				end else if (n < 90) begin
					if ($urandom_range(0, 1) == 0 || limit_cfg == mld_pkg::MAX_LENGTH_RESET)
						push_header(magic_cfg, {1'b1, 31'($urandom)});
					else
						push_header(magic_cfg, {1'b0, limit_cfg} + $urandom_range(1, 4));
				end else begin
					// Broken stream: stray bytes or a message cut short ends the phase.
					if ($urandom_range(0, 1) == 0) begin
						push_payload($urandom_range(1, 7));
					end else begin
						len = $urandom_range(4, 12);
						push_header(magic_cfg, len);
						push_payload($urandom_range(1, int'(len) - 1));
					end
					cut = 1'b1;
				end
			end
			wait_idle();
			phase++;
		end

		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
rtl/mld_pkg.sv
rtl/mld_cfg.sv
rtl/mld_parse.sv
rtl/mld_out.sv
rtl/magic_length_message_deframer_top.sv
tb/magic_length_message_deframer_top_test.sv
